// File: sv/xtea_pkg.sv
package xtea_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_KEYS   = 4;
    localparam int KEY_SEL_W  = 2;
    localparam int CYC_W      = 7;
    localparam int MAX_CYCLES = 64;
    // Half-round counter holds up to twice the cycle limit
    localparam int HALF_W     = $clog2(2 * MAX_CYCLES + 1);
    localparam int NUM_REGS   = 6;
    localparam int IDX_W      = 3;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [IDX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DELTA  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CYCLES = 3'd5;

    localparam logic [WORD_W-1:0] DELTA_RESET  = 32'h9E37_79B9;
    localparam logic [CYC_W-1:0]  CYCLES_RESET = 7'd64;

    typedef logic [WORD_W-1:0] word_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;     // capture a new block, clear the running sum
        logic step;     // run one half-round
        logic second;   // step updates the high word (second half-round)
        logic store;    // move the finished block to the output register
    } xtea_cmd_t;

    // Add the shifted-and-xored word back onto itself
    function automatic word_t mix_word(input word_t w);
        mix_word = ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage

// File: sv/xtea_block_encipher_unit.sv
// XTEA encipher for one 64-bit block (low word in tdata[31:0]). The key, the
// round delta and the cycle count come from a write-only register port; counts
// above 64 are clamped to 64 and a count of zero passes the block through. One
// shared half-round unit runs a half-round per clock. A new block is taken once
// the previous one has moved to the output register, so a result waiting on
// m_tready does not hold up the next block's rounds.
module xtea_block_encipher_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,   // plain_low_word, plain_high_word
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,   // cipher_low_word, cipher_high_word
    input  logic                       cfg_wr_en,
    input  logic [xtea_pkg::IDX_W-1:0] cfg_index,
    input  logic [31:0]                cfg_wdata
);
    import xtea_pkg::*;

    word_t             key_reg [NUM_KEYS];
    word_t             delta_reg;
    logic [CYC_W-1:0]  cycles_reg;
    xtea_cmd_t         cmd;
    word_t             out_low, out_high;

    // Configuration register file; writes past the list drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                key_reg[i] <= '0;
            end
            delta_reg  <= DELTA_RESET;
            cycles_reg <= CYCLES_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KEY0:   key_reg[0] <= cfg_wdata;
                REG_KEY1:   key_reg[1] <= cfg_wdata;
                REG_KEY2:   key_reg[2] <= cfg_wdata;
                REG_KEY3:   key_reg[3] <= cfg_wdata;
                REG_DELTA:  delta_reg  <= cfg_wdata;
                REG_CYCLES: cycles_reg <= cfg_wdata[CYC_W-1:0];
                default: ;
            endcase
        end
    end

    xtea_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cycle_count (cycles_reg),
        .cmd         (cmd)
    );

    xtea_dp u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .in_low      (s_tdata[31:0]),
        .in_high     (s_tdata[63:32]),
        .key_word    (key_reg),
        .round_delta (delta_reg),
        .out_low     (out_low),
        .out_high    (out_high)
    );

    assign m_tdata = {out_high, out_low};

    // A beat in starts work, so the input closes on the next clock
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after block load");

    // Never overwrite a result that has not been taken
    a_store_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |-> (!m_tvalid || m_tready))
        else $error("output register overwritten");

    // Loading excludes both stepping and storing
    a_load_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && (cmd.step || cmd.store)))
        else $error("load overlaps round or store");

    // A stored result shows up as valid on the next clock
    a_store_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.store |=> m_tvalid)
        else $error("stored result not presented");

endmodule

// File: sv/xtea_ctrl.sv
module xtea_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [xtea_pkg::CYC_W-1:0]   cycle_count,
    output xtea_pkg::xtea_cmd_t          cmd
);
    import xtea_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [HALF_W-1:0] half_reg, half_next;
    logic              out_valid_reg, out_valid_next;
    logic [CYC_W-1:0]  eff_cycles;
    logic [HALF_W-1:0] load_halves;
    logic              accept;

    // Clamp the cycle count to the supported limit
    assign eff_cycles  = (cycle_count > CYC_W'(MAX_CYCLES)) ? CYC_W'(MAX_CYCLES)
                                                            : cycle_count;
    assign load_halves = {eff_cycles, 1'b0};

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        // Even count left means the low word is next
        cmd.second     = half_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load  = 1'b1;
                    half_next = load_halves;
                    state_next = (load_halves == '0) ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step  = 1'b1;
                half_next = half_reg - HALF_W'(1);
                if (half_reg == HALF_W'(1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold the block until the output register frees up
                if (!out_valid_reg || m_tready) begin
                    cmd.store      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            half_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/xtea_dp.sv
module xtea_dp (
    input  logic                 aclk,
    input  xtea_pkg::xtea_cmd_t  cmd,
    input  xtea_pkg::word_t      in_low,
    input  xtea_pkg::word_t      in_high,
    input  xtea_pkg::word_t      key_word [xtea_pkg::NUM_KEYS],
    input  xtea_pkg::word_t      round_delta,
    output xtea_pkg::word_t      out_low,
    output xtea_pkg::word_t      out_high
);
    import xtea_pkg::*;

    word_t v0_reg, v1_reg, sum_reg;
    word_t out_low_reg, out_high_reg;
    word_t mix_in, mixed, sum_key, delta_add;
    logic [KEY_SEL_W-1:0] key_sel;

    // One shared half-round: mix the other word, xor in the key-plus-sum term
    assign mix_in    = cmd.second ? v0_reg : v1_reg;
    assign key_sel   = cmd.second ? sum_reg[12:11] : sum_reg[1:0];
    assign sum_key   = sum_reg + key_word[key_sel];
    assign mixed     = mix_word(mix_in) ^ sum_key;
    assign delta_add = sum_reg + round_delta;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v0_reg  <= in_low;
            v1_reg  <= in_high;
            sum_reg <= '0;
        end else if (cmd.step) begin
            if (cmd.second) begin
                v1_reg <= v1_reg + mixed;
            end else begin
                v0_reg  <= v0_reg + mixed;
                sum_reg <= delta_add;
            end
        end
        if (cmd.store) begin
            out_low_reg  <= v0_reg;
            out_high_reg <= v1_reg;
        end
    end

    assign out_low  = out_low_reg;
    assign out_high = out_high_reg;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

    import xtea_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int DIRECTED_ROWS   = 16;
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HOLD_CYCLES     = 500;
    localparam int TAIL_CYCLES     = 2 * MAX_CYCLES + 10;

    // Indexes past the register list; writes there must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // One 64-bit block, low word in the low bits as on tdata
    typedef struct packed {
        word_t high_word;
        word_t low_word;
    } block_t;

    typedef struct {
        logic             reconfig;
        logic [CYC_W-1:0] cycles;
        word_t            delta;
        logic [127:0]     key_bits;   // key word 0 in the low bits
        block_t           plain;
        logic             known;
        block_t           cipher;
    } directed_row_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [63:0]        s_tdata   = '0;   // plain_low_word, plain_high_word
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [63:0]        m_tdata;          // cipher_low_word, cipher_high_word
    logic               cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;

    // Local copy of the cipher settings
    word_t              model_key [NUM_KEYS];
    word_t              model_delta;
    logic [CYC_W-1:0]   model_cycles;

    block_t             awaited_cipher [$];
    directed_row_t      directed_rows [DIRECTED_ROWS];
    int                 fails       = 0;
    int                 clock_ticks = 0;
    int                 tx_idle_pct = 0;
    int                 rx_idle_pct = 0;
    int                 hold_token  = 0;
    int                 hold_seen   = 0;
    int                 hold_left   = 0;

    xtea_block_encipher_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        clock_ticks <= clock_ticks + 1;
        if (clock_ticks > CYCLE_LIMIT) begin
            $display("xtea_block_encipher_unit test failed");
            $finish;
        end
    end

    // Encipher one block with the current settings; the sum restarts per block
    function automatic block_t encipher(input block_t plain);
        word_t  v0;
        word_t  v1;
        word_t  sum;
        int     rounds;
        block_t cipher;
        v0     = plain.low_word;
        v1     = plain.high_word;
        sum    = '0;
        rounds = (model_cycles > MAX_CYCLES) ? MAX_CYCLES : int'(model_cycles);
        for (int i = 0; i < rounds; i++) begin
            v0  += (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + model_key[sum[1:0]]);
            sum += model_delta;
            v1  += (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + model_key[sum[12:11]]);
        end
        cipher.low_word  = v0;
        cipher.high_word = v1;
        return cipher;
    endfunction

    // Mostly random words, with all-zero, all-one and one-hot mixed in
    function automatic word_t random_word();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    // Drive one register write; the register takes it at the next edge
    task automatic write_reg(input logic [IDX_W-1:0] idx, input word_t data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: model_key[idx[1:0]] = data;
            REG_DELTA:  model_delta  = data;
            REG_CYCLES: model_cycles = data[CYC_W-1:0];
            default: ;
        endcase
    endtask

    // Drop valid and hold until every block has come back
    task automatic wait_all_ciphers();
        s_tvalid <= 1'b0;
        while (awaited_cipher.size() != 0) @(posedge aclk);
    endtask

    // Load a full key, delta and cycle count while the unit is idle
    task automatic load_settings(input logic [127:0] key_bits, input word_t delta,
                                 input word_t cycles_data);
        wait_all_ciphers();
        write_reg(REG_SPARE_LO, $urandom());
        write_reg(REG_KEY0, key_bits[31:0]);
        write_reg(REG_KEY1, key_bits[63:32]);
        write_reg(REG_KEY2, key_bits[95:64]);
        write_reg(REG_KEY3, key_bits[127:96]);
        write_reg(REG_DELTA, delta);
        write_reg(REG_CYCLES, cycles_data);
        write_reg(REG_SPARE_HI, $urandom());
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one plaintext beat; valid stays high into the next beat unless a gap falls
    task automatic send_block(input block_t plain, input logic known, input block_t cipher);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= plain;
        do @(posedge aclk); while (!s_tready);
        awaited_cipher.insert(awaited_cipher.size(), known ? cipher : encipher(plain));
    endtask

    // Check cipher beats in order and drive ready
    always @(posedge aclk) begin
        block_t got;
        block_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (awaited_cipher.size() == 0) begin
                $display("%0t: cipher beat with none awaited, got %h", $time, got);
                fails++;
            end else begin
                want = awaited_cipher.pop_front();
                if (got.low_word !== want.low_word) begin
                    $display("%0t: cipher_low_word expected %h actual %h",
                             $time, want.low_word, got.low_word);
                    fails++;
                end
                if (got.high_word !== want.high_word) begin
                    $display("%0t: cipher_high_word expected %h actual %h",
                             $time, want.high_word, got.high_word);
                    fails++;
                end
            end
        end
        // A new token starts a long hold-off on the result side
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        logic [127:0]     key_bits;
        word_t            delta;
        logic [CYC_W-1:0] cycles;
        block_t           plain;

        // Directed rows: reset state, pass-through, saturation, extremes
        directed_rows[0]  = '{1'b0, 7'd0, 32'h0, 128'h0,
                              64'h0000_0000_0000_0000, 1'b0, 64'h0};
        directed_rows[1]  = '{1'b0, 7'd0, 32'h0, 128'h0,
                              64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0};
        directed_rows[2]  = '{1'b1, 7'd0, DELTA_RESET, {4{32'hFFFF_FFFF}},
                              64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
        directed_rows[3]  = '{1'b1, 7'd0, 32'h1234_5678, 128'h0,
                              64'h9ABC_DEF0_1234_5678, 1'b1, 64'h9ABC_DEF0_1234_5678};
        directed_rows[4]  = '{1'b1, 7'd1, 32'h0, 128'h0,
                              64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000};
        directed_rows[5]  = '{1'b0, 7'd1, 32'h0, 128'h0,
                              64'h0000_0001_0000_0000, 1'b1, 64'h0000_0122_0000_0011};
        directed_rows[6]  = '{1'b1, 7'd1, 32'hFFFF_FFFF, {4{32'hFFFF_FFFF}},
                              64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0};
        directed_rows[7]  = '{1'b1, 7'd64, 32'hFFFF_FFFF, {4{32'hFFFF_FFFF}},
                              64'h0000_0000_0000_0000, 1'b0, 64'h0};
        directed_rows[8]  = '{1'b1, 7'd32, DELTA_RESET,
                              128'h0C0D0E0F_08090A0B_04050607_00010203,
                              64'h4142_4344_4546_4748, 1'b0, 64'h0};
        directed_rows[9]  = '{1'b1, 7'd64, DELTA_RESET,
                              128'h0C0D0E0F_08090A0B_04050607_00010203,
                              64'h4546_4748_4142_4344, 1'b0, 64'h0};
        directed_rows[10] = '{1'b1, 7'd65, DELTA_RESET,
                              128'h0C0D0E0F_08090A0B_04050607_00010203,
                              64'h4546_4748_4142_4344, 1'b0, 64'h0};
        directed_rows[11] = '{1'b1, 7'd127, 32'h0BAD_F00D,
                              128'hDEADBEEF_CAFEBABE_01234567_89ABCDEF,
                              64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0};
        directed_rows[12] = '{1'b1, 7'd3, 32'h0000_0800,
                              128'h33333333_22222222_11111111_00000000,
                              64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0};
        directed_rows[13] = '{1'b1, 7'd8, 32'h8000_0000,
                              128'h80000000_00000001_7FFFFFFF_FFFFFFFE,
                              64'h7FFF_FFFF_8000_0000, 1'b0, 64'h0};
        directed_rows[14] = '{1'b1, 7'd2, 32'h0000_0001,
                              128'h00000004_00000003_00000002_00000001,
                              64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0};
        directed_rows[15] = '{1'b1, 7'd64, DELTA_RESET,
                              128'hA5A5A5A5_5A5A5A5A_F0F0F0F0_0F0F0F0F,
                              64'h0000_0000_FFFF_FFFF, 1'b0, 64'h0};

        // Settings after reset
        for (int k = 0; k < NUM_KEYS; k++) model_key[k] = '0;
        model_delta  = DELTA_RESET;
        model_cycles = CYCLES_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 25;
        rx_idle_pct <= 65;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].reconfig)
                load_settings(directed_rows[r].key_bits, directed_rows[r].delta,
                              {25'b0, directed_rows[r].cycles});
            send_block(directed_rows[r].plain, directed_rows[r].known,
                       directed_rows[r].cipher);
        end

        // Random phases, each under one setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 5) begin
                tx_idle_pct = 25;
                rx_idle_pct <= 65;
            end else if (p < 10) begin
                tx_idle_pct = 65;
                rx_idle_pct <= 25;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end

            for (int k = 0; k < NUM_KEYS; k++) begin
                case (p % 5)
                    0: key_bits[32*k +: 32] = '0;
                    1: key_bits[32*k +: 32] = '1;
                    default: key_bits[32*k +: 32] = $urandom();
                endcase
            end
            if (p == 2)           delta = '0;
            else if (p == 6)      delta = '1;
            else if (p % 3 == 0)  delta = DELTA_RESET;
            else                  delta = $urandom();

            // Keep most phases short; a few hit the largest counts
            case (p)
                1: cycles = 7'd64;
                3: cycles = 7'd127;
                5: cycles = 7'd0;
                7: cycles = 7'd1;
                9: cycles = 7'd65;
                default: begin
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5, 6: cycles = CYC_W'($urandom_range(1, 16));
                        7, 8:                cycles = CYC_W'($urandom_range(17, 64));
                        default:             cycles = CYC_W'($urandom_range(65, 127));
                    endcase
                end
            endcase
            load_settings(key_bits, delta, ($urandom() & 32'hFFFF_FF80) | {25'b0, cycles});

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Stall the result side long enough to back up the input
                if (p == 2 && n == 20) hold_token <= hold_token + 1;
                // Let the unit run dry in the middle of a phase
                if (p == 7 && n == 60) wait_all_ciphers();
                plain.low_word  = random_word();
                plain.high_word = random_word();
                send_block(plain, 1'b0, '0);
            end
        end

        wait_all_ciphers();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fails == 0) begin
            $display("xtea_block_encipher_unit test passed");
        end else begin
            $display("xtea_block_encipher_unit test failed");
        end
        $finish;
    end

endmodule
